### rtl/jh2d_pkg.sv
// shared types, widths and codes for the joint intensity histogram
`timescale 1ns / 1ps
package jh2d_pkg;

    localparam int VALUE_W     = 16;
    localparam int STEP_W      = 13;
    localparam int BIN_OUT_W   = 9;
    localparam int COUNT_OUT_W = 32;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int MAX_BINS_DEF    = 512;
    localparam int COUNT_WIDTH_DEF = 32;

    // bin = (2*d + s) / (2*s): dividend needs 18 bits, divisor 14 bits
    localparam int DIVIDEND_W = VALUE_W + 2;
    localparam int DIVISOR_W  = STEP_W + 1;
    localparam int DIV_STEPS  = DIVIDEND_W;

    localparam logic [VALUE_W-1:0] RANGE_MIN_RST = VALUE_W'(10);
    localparam logic [VALUE_W-1:0] RANGE_MAX_RST = VALUE_W'(5000);
    localparam logic [STEP_W-1:0]  BIN_STEP_RST  = STEP_W'(10);

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_STEP  = CFG_IDX_W'(2);

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    localparam logic [STATUS_W-1:0] ST_COUNTED   = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_MASKED    = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_BEYOND    = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_READ      = STATUS_W'(4);

    typedef struct packed {
        logic                 operation;
        logic                 inside_mask;
        logic [VALUE_W-1:0]   value_a;
        logic [VALUE_W-1:0]   value_b;
        logic [BIN_OUT_W-1:0] read_row;
        logic [BIN_OUT_W-1:0] read_col;
    } t_hist_in;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] bin_count;
        logic [BIN_OUT_W-1:0]   row_bin;
        logic [BIN_OUT_W-1:0]   col_bin;
    } t_hist_out;

endpackage

### rtl/joint_histogram_2d_unit.sv
// joint intensity histogram: divider, counter store and control sequencer
`timescale 1ns / 1ps
// Counts voxel intensity pairs into a MAX_BINS x MAX_BINS store of saturating
// counters held in one synchronous RAM. After reset the block sweeps the RAM to
// zero, one entry per cycle, over every entry, with busy high; configuration
// writes are taken during the sweep. One transaction at a time is accepted
// (start while busy is low). An item that is masked out, out of range or a read
// of a bin beyond the store returns its result in the cycle after start. A read
// of a stored bin passes through S_FETCH and S_UPDATE. A voxel that reaches the
// binning step goes through two restoring dividers that share the divisor (one
// quotient bit per cycle for both axes) in S_DIV, then forms the RAM address in
// S_BIN; a bin beyond the store returns its result there. A bin inside the store
// then goes through S_FETCH and S_UPDATE for the RAM read-modify-write. Busy
// drops in the cycle the result appears, so the next start can be taken as the
// result leaves.
// Each result appears for exactly one cycle with o_valid high; the receiver
// cannot stall it, so it must take every result as it comes.
module joint_histogram_2d_unit
    import jh2d_pkg::*;
#(
    parameter int MAX_BINS    = MAX_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_hist_in              i_item,
    output logic                  o_valid,
    output t_hist_out             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int ADDR_W = 2 * BIN_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int DCNT_W = $clog2(DIV_STEPS);
    localparam int REM_W  = DIVISOR_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_BIN,
        S_FETCH,
        S_UPDATE
    } t_state;

    t_state                   r_state;
    logic [VALUE_W-1:0]       r_range_min;
    logic [VALUE_W-1:0]       r_range_max;
    logic [STEP_W-1:0]        r_bin_step;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic [ADDR_W-1:0]        r_addr;
    logic                     r_op;
    logic [BIN_OUT_W-1:0]     r_row_out;
    logic [BIN_OUT_W-1:0]     r_col_out;
    logic [DCNT_W-1:0]        r_div_cnt;
    logic [DIVISOR_W-1:0]     r_divisor;
    logic [DIVIDEND_W-1:0]    r_quo_a;
    logic [DIVIDEND_W-1:0]    r_quo_b;
    logic [REM_W-1:0]         r_rem_a;
    logic [REM_W-1:0]         r_rem_b;
    logic [COUNT_WIDTH-1:0]   r_rd_data;
    logic                     r_valid;
    t_hist_out                r_result;

    logic [COUNT_WIDTH-1:0]   mem [0:DEPTH-1];

    // restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic logic [REM_W+DIVIDEND_W-1:0] div_step(
        input logic [REM_W-1:0]      rem,
        input logic [DIVIDEND_W-1:0] quo,
        input logic [DIVISOR_W-1:0]  dsr
    );
        logic [REM_W:0]   rem_sh;
        logic [REM_W:0]   diff;
        logic [REM_W-1:0] rem_n;
        logic             qbit;
        rem_sh = {rem, quo[DIVIDEND_W-1]};
        diff   = rem_sh - (REM_W+1)'(dsr);
        qbit   = (rem_sh >= (REM_W+1)'(dsr));
        rem_n  = qbit ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        return {rem_n, quo[DIVIDEND_W-2:0], qbit};
    endfunction

    logic [REM_W+DIVIDEND_W-1:0] step_a;
    logic [REM_W+DIVIDEND_W-1:0] step_b;
    logic [STEP_W-1:0]           step_eff;
    logic [VALUE_W-1:0]          diff_a;
    logic [VALUE_W-1:0]          diff_b;
    logic                        in_range;
    logic [BIN_W+8:0]            rd_row_ext;
    logic [BIN_W+8:0]            rd_col_ext;
    logic                        rd_in_store;
    logic                        bins_in_store;
    logic [COUNT_WIDTH-1:0]      n_count;
    logic [COUNT_WIDTH+31:0]     count_ext;
    logic [COUNT_WIDTH+31:0]     rd_ext;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [COUNT_WIDTH-1:0]      mem_wdata;

    always_comb begin
        step_a        = div_step(r_rem_a, r_quo_a, r_divisor);
        step_b        = div_step(r_rem_b, r_quo_b, r_divisor);
        step_eff      = (r_bin_step == '0) ? STEP_W'(1) : r_bin_step;
        diff_a        = i_item.value_a - r_range_min;
        diff_b        = i_item.value_b - r_range_min;
        in_range      = (i_item.value_a >= r_range_min) && (i_item.value_a <= r_range_max) &&
                        (i_item.value_b >= r_range_min) && (i_item.value_b <= r_range_max);
        rd_row_ext    = (BIN_W+9)'(i_item.read_row);
        rd_col_ext    = (BIN_W+9)'(i_item.read_col);
        rd_in_store   = (rd_row_ext < (BIN_W+9)'(MAX_BINS)) &&
                        (rd_col_ext < (BIN_W+9)'(MAX_BINS));
        bins_in_store = (r_quo_a < DIVIDEND_W'(MAX_BINS)) &&
                        (r_quo_b < DIVIDEND_W'(MAX_BINS));
        n_count       = (&r_rd_data) ? r_rd_data : r_rd_data + COUNT_WIDTH'(1);
        count_ext     = (COUNT_WIDTH+32)'(n_count);
        rd_ext        = (COUNT_WIDTH+32)'(r_rd_data);
        mem_we        = (r_state == S_CLEAR) ||
                        ((r_state == S_UPDATE) && (r_op == OP_ACCUMULATE));
        mem_waddr     = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
        mem_wdata     = (r_state == S_CLEAR) ? '0 : n_count;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_valid     <= 1'b0;
            r_range_min <= RANGE_MIN_RST;
            r_range_max <= RANGE_MAX_RST;
            r_bin_step  <= BIN_STEP_RST;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RANGE_MIN: r_range_min <= i_cfg_data[VALUE_W-1:0];
                    CFG_RANGE_MAX: r_range_max <= i_cfg_data[VALUE_W-1:0];
                    CFG_BIN_STEP:  r_bin_step  <= i_cfg_data[STEP_W-1:0];
                    default:       ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op <= i_item.operation;
                        if (i_item.operation == OP_READ) begin
                            r_row_out <= i_item.read_row;
                            r_col_out <= i_item.read_col;
                            r_addr    <= {rd_row_ext[BIN_W-1:0], rd_col_ext[BIN_W-1:0]};
                            if (rd_in_store) begin
                                r_state <= S_FETCH;
                            end else begin
                                r_valid  <= 1'b1;
                                r_result <= '{status: ST_READ, bin_count: '0,
                                              row_bin: i_item.read_row,
                                              col_bin: i_item.read_col};
                            end
                        end else if (!i_item.inside_mask) begin
                            r_valid  <= 1'b1;
                            r_result <= '{status: ST_MASKED, bin_count: '0,
                                          row_bin: '0, col_bin: '0};
                        end else if (!in_range) begin
                            r_valid  <= 1'b1;
                            r_result <= '{status: ST_OUT_RANGE, bin_count: '0,
                                          row_bin: '0, col_bin: '0};
                        end else begin
                            r_divisor <= {step_eff, 1'b0};
                            r_quo_a   <= {1'b0, diff_a, 1'b0} + DIVIDEND_W'(step_eff);
                            r_quo_b   <= {1'b0, diff_b, 1'b0} + DIVIDEND_W'(step_eff);
                            r_rem_a   <= '0;
                            r_rem_b   <= '0;
                            r_div_cnt <= DCNT_W'(DIV_STEPS - 1);
                            r_state   <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    {r_rem_a, r_quo_a} <= step_a;
                    {r_rem_b, r_quo_b} <= step_b;
                    r_div_cnt          <= r_div_cnt - DCNT_W'(1);
                    if (r_div_cnt == '0) begin
                        r_state <= S_BIN;
                    end
                end
                S_BIN: begin
                    // quotients settled after the last divide step
                    r_row_out <= r_quo_a[BIN_OUT_W-1:0];
                    r_col_out <= r_quo_b[BIN_OUT_W-1:0];
                    r_addr    <= {r_quo_a[BIN_W-1:0], r_quo_b[BIN_W-1:0]};
                    if (bins_in_store) begin
                        r_state <= S_FETCH;
                    end else begin
                        r_valid  <= 1'b1;
                        r_result <= '{status: ST_BEYOND, bin_count: '0,
                                      row_bin: r_quo_a[BIN_OUT_W-1:0],
                                      col_bin: r_quo_b[BIN_OUT_W-1:0]};
                        r_state  <= S_IDLE;
                    end
                end
                S_FETCH: begin
                    // ram data for r_addr lands in r_rd_data at this edge
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_op == OP_ACCUMULATE) begin
                        r_result <= '{status: ST_COUNTED,
                                      bin_count: count_ext[COUNT_OUT_W-1:0],
                                      row_bin: r_row_out, col_bin: r_col_out};
                    end else begin
                        r_result <= '{status: ST_READ,
                                      bin_count: rd_ext[COUNT_OUT_W-1:0],
                                      row_bin: r_row_out, col_bin: r_col_out};
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### tb/sv/jh2d_histogram_checker.sv
// result checker for the joint histogram: predicts every transaction and compares
`timescale 1ns / 1ps
module jh2d_histogram_checker
    import jh2d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_hist_in              i_item,
    input  logic                  i_valid,
    input  t_hist_out             i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int CELLS = MAX_BINS_DEF * MAX_BINS_DEF;

    bit   [COUNT_WIDTH_DEF-1:0] bin_tally [CELLS];
    logic [VALUE_W-1:0]         lo_cfg;
    logic [VALUE_W-1:0]         hi_cfg;
    logic [STEP_W-1:0]          step_cfg;
    t_hist_out                  due_results [$];
    t_hist_out                  want;
    int                         err_count;

    initial begin
        err_count = 0;
        o_pending = 0;
    end

    assign o_errors = err_count;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned exp_val);
        $display("%0t ns: histogram mismatch on %s: got %0d, wanted %0d",
                 $time, what, got, exp_val);
        err_count++;
    endtask

    // bin of one intensity, round to nearest with ties up
    function automatic int unsigned intensity_bin(input logic [VALUE_W-1:0] v);
        int unsigned s;
        int unsigned d;
        s = (step_cfg == '0) ? 1 : int'(step_cfg);
        d = int'(v) - int'(lo_cfg);
        return (2 * d + s) / (2 * s);
    endfunction

    function automatic t_hist_out histogram_step(input t_hist_in it);
        t_hist_out   res;
        int unsigned r;
        int unsigned c;
        int unsigned slot;
        res = '0;
        if (it.operation == OP_READ) begin
            res.status  = ST_READ;
            res.row_bin = it.read_row;
            res.col_bin = it.read_col;
            if (it.read_row < MAX_BINS_DEF && it.read_col < MAX_BINS_DEF)
                res.bin_count = COUNT_OUT_W'(bin_tally[it.read_row * MAX_BINS_DEF + it.read_col]);
        end else if (!it.inside_mask) begin
            res.status = ST_MASKED;
        end else if (it.value_a < lo_cfg || it.value_a > hi_cfg ||
                     it.value_b < lo_cfg || it.value_b > hi_cfg) begin
            res.status = ST_OUT_RANGE;
        end else begin
            r = intensity_bin(it.value_a);
            c = intensity_bin(it.value_b);
            res.row_bin = BIN_OUT_W'(r);
            res.col_bin = BIN_OUT_W'(c);
            if (r >= MAX_BINS_DEF || c >= MAX_BINS_DEF) begin
                res.status = ST_BEYOND;
            end else begin
                slot = r * MAX_BINS_DEF + c;
                // counters saturate at all ones
                if (bin_tally[slot] != '1)
                    bin_tally[slot] = bin_tally[slot] + 1'b1;
                res.status    = ST_COUNTED;
                res.bin_count = COUNT_OUT_W'(bin_tally[slot]);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lo_cfg   <= RANGE_MIN_RST;
            hi_cfg   <= RANGE_MAX_RST;
            step_cfg <= BIN_STEP_RST;
            due_results.delete();
        end else begin
            if (i_valid) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with no transaction outstanding",
                                    i_result.status, 0);
                end else begin
                    want = due_results.pop_front();
                    if (i_result.status !== want.status)
                        report_mismatch("status", i_result.status, want.status);
                    if (i_result.bin_count !== want.bin_count)
                        report_mismatch("bin_count", i_result.bin_count, want.bin_count);
                    if (i_result.row_bin !== want.row_bin)
                        report_mismatch("row_bin", i_result.row_bin, want.row_bin);
                    if (i_result.col_bin !== want.col_bin)
                        report_mismatch("col_bin", i_result.col_bin, want.col_bin);
                end
            end
            if (i_start && !i_busy)
                due_results.push_back(histogram_step(i_item));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RANGE_MIN: lo_cfg <= i_cfg_data;
                    CFG_RANGE_MAX: hi_cfg <= i_cfg_data;
                    CFG_BIN_STEP: step_cfg <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= due_results.size();
    end

endmodule

### tb/sv/joint_histogram_2d_unit_test.sv
// testbench top for the joint histogram: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module joint_histogram_2d_unit_test;
    import jh2d_pkg::*;

    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 195;
    localparam int IDLE_PCT    = 26;
    // covers the store clearing sweep after reset with margin
    localparam int STALL_LIMIT = 1000000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_hist_in              hist_item;
    logic                  hist_valid;
    t_hist_out             hist_result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    errors;

    int          ph_lo   [N_PHASES] = '{10, 0, 0, 100, 1000, 500, 65535, 0, 0};
    int          ph_hi   [N_PHASES] = '{5000, 65535, 65535, 200, 1300, 400, 65535, 0, 0};
    int          ph_step [N_PHASES] = '{10, 1, 128, 4096, 0, 7, 4096, 1, 1};
    logic [17:0] hot_bins [$];
    int          status_seen [8];
    int          item_total;
    int          settings_written;
    int          stall_cycles;

    joint_histogram_2d_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (hist_item),
        .o_valid     (hist_valid),
        .o_result    (hist_result),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    jh2d_histogram_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (hist_item),
        .i_valid     (hist_valid),
        .i_result    (hist_result),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // remember bins that were actually counted so reads hit live counters
    always @(posedge clk) begin
        if (rst_n && hist_valid) begin
            status_seen[hist_result.status]++;
            if (hist_result.status == ST_COUNTED) begin
                hot_bins.push_back({hist_result.row_bin, hist_result.col_bin});
                if (hot_bins.size() > 32)
                    void'(hot_bins.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || hist_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic t_hist_in make_voxel(input logic mask, input int a, input int b);
        t_hist_in it;
        it             = '0;
        it.operation   = OP_ACCUMULATE;
        it.inside_mask = mask;
        it.value_a     = VALUE_W'(a);
        it.value_b     = VALUE_W'(b);
        it.read_row    = BIN_OUT_W'($urandom);
        it.read_col    = BIN_OUT_W'($urandom);
        return it;
    endfunction

    // mask and intensities are don't-care for a read, so fill them randomly
    function automatic t_hist_in make_read(input int row, input int col);
        t_hist_in it;
        it             = make_voxel(1'($urandom), $urandom, $urandom);
        it.operation   = OP_READ;
        it.read_row    = BIN_OUT_W'(row);
        it.read_col    = BIN_OUT_W'(col);
        return it;
    endfunction

    function automatic int pick_intensity(input int lo, input int hi, input int step,
                                          input int hot);
        int s;
        int span;
        int pick;
        s    = (step == 0) ? 1 : step;
        span = 2 * s;
        if (hi > hot && span > hi - hot)
            span = hi - hot;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return (hot + $urandom_range(0, span)) & 16'hffff;
        if (pick < 60)
            return (lo <= hi) ? $urandom_range(lo, hi) : $urandom & 16'hffff;
        if (pick < 75) begin
            case ($urandom_range(0, 3))
                0: return lo;
                1: return hi;
                2: return (lo - 1) & 16'hffff;
                default: return (hi + 1) & 16'hffff;
            endcase
        end
        return $urandom & 16'hffff;
    endfunction

    function automatic t_hist_in random_item(input int lo, input int hi, input int step,
                                             input int hot);
        t_hist_in it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            it = make_read($urandom_range(0, 511), $urandom_range(0, 511));
            if (pick < 2)
                {it.read_row, it.read_col} = {BIN_OUT_W'(511), BIN_OUT_W'(511)};
            else if (hot_bins.size() > 0 && $urandom_range(0, 2) != 0)
                {it.read_row, it.read_col} = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
        end else begin
            it = make_voxel($urandom_range(0, 9) != 0, pick_intensity(lo, hi, step, hot),
                            pick_intensity(lo, hi, step, hot));
        end
        return it;
    endfunction

    // start stays high from one transaction to the next unless a gap is taken
    task automatic send_item(input t_hist_in it, input bit allow_gap);
        if (allow_gap) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start     <= 1'b1;
        hist_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        item_total++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic apply_setting(input int lo, input int hi, input int step);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RANGE_MIN;
        cfg_data  <= CFG_DATA_W'(lo);
        @(negedge clk);
        cfg_index <= CFG_RANGE_MAX;
        cfg_data  <= CFG_DATA_W'(hi);
        @(negedge clk);
        cfg_index <= CFG_BIN_STEP;
        cfg_data  <= CFG_DATA_W'(step);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    initial begin
        int lo;
        int hi;
        int step;
        int hot;
        int ph;
        int n;
        rst_n            = 1'b0;
        start            = 1'b0;
        hist_item        = '0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_RANGE_MIN;
        cfg_data         = '0;
        item_total       = 0;
        settings_written = 0;
        stall_cycles     = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // reset setting: range 10..5000, step 10
        send_item(make_voxel(1'b1, 10, 10), 1'b0);
        send_item(make_voxel(1'b1, 10, 10), 1'b0);
        send_item(make_voxel(1'b1, 5000, 5000), 1'b0);
        send_item(make_voxel(1'b1, 15, 14), 1'b0);     // tie rounds up, just below does not
        send_item(make_voxel(1'b1, 9, 100), 1'b0);
        send_item(make_voxel(1'b1, 100, 5001), 1'b0);
        send_item(make_voxel(1'b0, 10, 10), 1'b0);
        send_item(make_voxel(1'b1, 0, 65535), 1'b0);
        send_item(make_voxel(1'b0, 65535, 0), 1'b0);
        send_item(make_read(0, 0), 1'b0);
        send_item(make_read(499, 499), 1'b0);
        send_item(make_read(1, 0), 1'b0);
        send_item(make_read(511, 511), 1'b0);

        // full range, unit step: bins past the store edge
        apply_setting(0, 65535, 1);
        send_item(make_voxel(1'b1, 0, 0), 1'b0);
        send_item(make_voxel(1'b1, 511, 511), 1'b0);
        send_item(make_voxel(1'b1, 0, 511), 1'b0);
        send_item(make_voxel(1'b1, 512, 0), 1'b0);
        send_item(make_voxel(1'b1, 65535, 65535), 1'b0);
        send_item(make_read(511, 511), 1'b0);
        send_item(make_read(0, 511), 1'b0);
        send_item(make_read(0, 0), 1'b0);

        for (ph = 0; ph < N_PHASES; ph++) begin
            lo   = ph_lo[ph];
            hi   = ph_hi[ph];
            step = ph_step[ph];
            if (ph == N_PHASES - 1) begin
                lo   = $urandom_range(0, 30000);
                hi   = lo + $urandom_range(0, 35535);
                step = $urandom_range(1, 300);
            end
            apply_setting(lo, hi, step);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    hot = lo;
                    if (hi > lo)
                        hot = lo + $urandom_range(0, (hi - lo < 400 * (step + 1)) ?
                                                     hi - lo : 400 * (step + 1));
                end
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    drain_results();
                // one whole setting runs back to back
                send_item(random_item(lo, hi, step, hot), ph != 2);
            end
        end

        drain_results();
        repeat (25) @(posedge clk);
        $display("ran %0d transactions over %0d register settings (zero step, inverted range,",
                 item_total, settings_written);
        $display("  max step, full range): counted %0d masked %0d range %0d beyond %0d read %0d",
                 status_seen[ST_COUNTED], status_seen[ST_MASKED], status_seen[ST_OUT_RANGE],
                 status_seen[ST_BEYOND], status_seen[ST_READ]);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
